>>> design/ecc_pkg.sv
// Shared types, codes and helpers for the elevator car controller.
package ecc_pkg;

  // Fixed field widths
  localparam int FLOOR_W = 4;
  localparam int SUB_W   = 2;
  localparam int LAMP_W  = 16;
  localparam int DEFAULT_NUM_FLOORS = 16;

  // Last quarter step before the next floor
  localparam logic [SUB_W-1:0] QUARTERS_TOP = 2'd3;

  // Event types
  localparam logic [1:0] EV_TICK     = 2'd0;
  localparam logic [1:0] EV_ACTION   = 2'd1;
  localparam logic [1:0] EV_LAMP_ON  = 2'd2;
  localparam logic [1:0] EV_LAMP_OFF = 2'd3;

  // Action codes
  localparam logic [2:0] ACT_UP    = 3'd0;
  localparam logic [2:0] ACT_DOWN  = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_ESTOP = 3'd3;
  localparam logic [2:0] ACT_OPEN  = 3'd4;
  localparam logic [2:0] ACT_CLOSE = 3'd5;

  // Car mode codes as reported
  localparam logic [2:0] MC_IDLE_CLOSED = 3'd0;
  localparam logic [2:0] MC_IDLE_OPEN   = 3'd1;
  localparam logic [2:0] MC_HALTED      = 3'd2;
  localparam logic [2:0] MC_OPENING     = 3'd3;
  localparam logic [2:0] MC_CLOSING     = 3'd4;
  localparam logic [2:0] MC_UP          = 3'd5;
  localparam logic [2:0] MC_DOWN        = 3'd6;

  // Direction codes
  localparam logic [1:0] DIR_STAND = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISMATCH  = 3'd1;
  localparam logic [2:0] ST_LIMIT     = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;
  localparam logic [2:0] ST_BAD_FLOOR = 3'd5;

  // Car mode state machine, one-hot
  typedef enum logic [6:0] {
    MODE_IDLE_CLOSED = 7'b0000001,
    MODE_IDLE_OPEN   = 7'b0000010,
    MODE_HALTED      = 7'b0000100,
    MODE_OPENING     = 7'b0001000,
    MODE_CLOSING     = 7'b0010000,
    MODE_UP          = 7'b0100000,
    MODE_DOWN        = 7'b1000000
  } mode_t;

  // Complete controller state
  typedef struct packed {
    logic [FLOOR_W-1:0] floor_num;
    logic [SUB_W-1:0]   sub_step;
    mode_t              mode;
    logic [1:0]         direction;
    logic               door;
    logic               pending_valid;
    logic [2:0]         pending_code;
    logic               motion_enabled;
    logic               stop_request;
    logic [LAMP_W-1:0]  lamps;
  } state_t;

  // Reported mode code for a one-hot mode
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    c = MC_IDLE_CLOSED;
    unique case (m)
      MODE_IDLE_CLOSED: c = MC_IDLE_CLOSED;
      MODE_IDLE_OPEN:   c = MC_IDLE_OPEN;
      MODE_HALTED:      c = MC_HALTED;
      MODE_OPENING:     c = MC_OPENING;
      MODE_CLOSING:     c = MC_CLOSING;
      MODE_UP:          c = MC_UP;
      MODE_DOWN:        c = MC_DOWN;
      default:          c = MC_IDLE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

>>> design/ecc_evt_if.sv
// Event channel: valid/ready handshake with the event payload.
interface ecc_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] action;
  logic [3:0] lamp_floor;

  modport source (output valid, mode, action, lamp_floor, input ready);
  modport sink   (input valid, mode, action, lamp_floor, output ready);
endinterface

>>> design/ecc_res_if.sv
// Result channel: valid/ready handshake with the car status payload.
interface ecc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  car_floor;
  logic [1:0]  sub_position;
  logic [2:0]  car_mode;
  logic [1:0]  travel_direction;
  logic        door_open;
  logic [15:0] lamp_bits;
  logic [2:0]  event_status;

  modport source (output valid, car_floor, sub_position, car_mode, travel_direction,
                  door_open, lamp_bits, event_status, input ready);
  modport sink   (input valid, car_floor, sub_position, car_mode, travel_direction,
                  door_open, lamp_bits, event_status, output ready);
endinterface

>>> design/elevator_car_controller.sv
// Elevator car controller: input register, event logic, state and result register.
//
// Usage: events (tick, action command, lamp on, lamp off) arrive on the evt
// channel; each event yields exactly one transaction on the res channel with
// the car floor, quarter position, mode, direction, door, call lamps and status.
// Both channels complete a transaction when valid and ready are high at a
// rising edge of clk.
// Flow: an event is captured in the input register, evaluated against the
// car state by the event logic, and loaded into the result register, which
// drives res.valid. Throughput: one event per cycle while the result register
// is not stalled, set by the combinational event logic between the input
// register and the state/result registers.
// Stall: when res.valid is high and res.ready is low the result register holds;
// the input register still fills, and evt.ready drops only when both registers are occupied.
// Reset (rst, synchronous, active high): the car is at floor 0, level, idle
// with the door closed, nothing pending, all lamps off, and both registers
// are empty.
module elevator_car_controller #(
  parameter int NUM_FLOORS = ecc_pkg::DEFAULT_NUM_FLOORS
) (
  input logic       clk,
  input logic       rst,
  ecc_evt_if.sink   evt,
  ecc_res_if.source res
);
  import ecc_pkg::*;

  // Input register
  logic       in_valid;
  logic [1:0] in_mode;
  logic [2:0] in_action;
  logic [3:0] in_lamp_floor;

  // Car state and result register
  state_t     state;
  state_t     state_next;
  logic [2:0] status_next;
  logic       out_valid;
  state_t     out_state;
  logic [2:0] out_status;

  logic       step_fire;

  assign step_fire = in_valid && (!out_valid || res.ready);
  assign evt.ready = !in_valid || step_fire;

  // Capture events
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
    if (evt.ready && evt.valid) begin
      in_mode       <= evt.mode;
      in_action     <= evt.action;
      in_lamp_floor <= evt.lamp_floor;
    end
  end

  ecc_step #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_step (
    .cur        (state),
    .ev         (in_mode),
    .act        (in_action),
    .lamp_floor (in_lamp_floor),
    .nxt        (state_next),
    .status     (status_next)
  );

  // Car state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state.floor_num      <= '0;
      state.sub_step       <= '0;
      state.mode           <= MODE_IDLE_CLOSED;
      state.direction      <= DIR_STAND;
      state.door           <= 1'b0;
      state.pending_valid  <= 1'b0;
      state.pending_code   <= ACT_UP;
      state.motion_enabled <= 1'b0;
      state.stop_request   <= 1'b0;
      state.lamps          <= '0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (step_fire) begin
      out_state  <= state_next;
      out_status <= status_next;
    end
  end

  assign res.valid            = out_valid;
  assign res.car_floor        = out_state.floor_num;
  assign res.sub_position     = out_state.sub_step;
  assign res.car_mode         = mode_code(out_state.mode);
  assign res.travel_direction = out_state.direction;
  assign res.door_open        = out_state.door;
  assign res.lamp_bits        = out_state.lamps;
  assign res.event_status     = out_status;

endmodule

>>> design/ecc_step.sv
// Next-state and status logic for one event.
module ecc_step #(
  parameter int NUM_FLOORS = ecc_pkg::DEFAULT_NUM_FLOORS
) (
  input  ecc_pkg::state_t cur,
  input  logic [1:0]      ev,
  input  logic [2:0]      act,
  input  logic [3:0]      lamp_floor,
  output ecc_pkg::state_t nxt,
  output logic [2:0]      status
);
  import ecc_pkg::*;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS - 1);
  localparam logic [FLOOR_W:0]   FLOOR_CNT = (FLOOR_W + 1)'(NUM_FLOORS);

  always_comb begin
    nxt    = cur;
    status = ST_OK;
    unique case (ev)
      EV_TICK: begin
        if (cur.pending_valid) begin
          // Apply the latched action against the current mode
          nxt.pending_valid  = 1'b0;
          nxt.motion_enabled = 1'b1;
          unique case (cur.pending_code)
            ACT_UP: begin
              if (cur.mode != MODE_IDLE_CLOSED && cur.mode != MODE_UP) begin
                status = ST_MISMATCH;
              end else if (cur.floor_num >= TOP_FLOOR) begin
                status = ST_LIMIT;
              end else begin
                nxt.mode      = MODE_UP;
                nxt.direction = DIR_UP;
              end
            end
            ACT_DOWN: begin
              if (cur.mode != MODE_IDLE_CLOSED && cur.mode != MODE_DOWN) begin
                status = ST_MISMATCH;
              end else if (cur.floor_num == '0) begin
                status = ST_LIMIT;
              end else begin
                nxt.mode      = MODE_DOWN;
                nxt.direction = DIR_DOWN;
              end
            end
            ACT_STOP: begin
              if (cur.mode != MODE_UP && cur.mode != MODE_DOWN) begin
                status = ST_MISMATCH;
              end else begin
                nxt.stop_request = 1'b1;
              end
            end
            ACT_ESTOP: begin
              nxt.mode         = MODE_HALTED;
              nxt.direction    = DIR_STAND;
              nxt.stop_request = 1'b0;
              status           = ST_HALTED;
            end
            ACT_OPEN: begin
              if (cur.mode != MODE_IDLE_CLOSED) status = ST_MISMATCH;
              else nxt.mode = MODE_OPENING;
            end
            ACT_CLOSE: begin
              if (cur.mode != MODE_IDLE_OPEN) status = ST_MISMATCH;
              else nxt.mode = MODE_CLOSING;
            end
            default: status = ST_MISMATCH;
          endcase
        end else if (cur.motion_enabled) begin
          // Advance the car or the door by one step
          unique case (cur.mode)
            MODE_HALTED:  status = ST_HALTED;
            MODE_OPENING: begin
              nxt.mode = MODE_IDLE_OPEN;
              nxt.door = 1'b1;
            end
            MODE_CLOSING: begin
              nxt.mode = MODE_IDLE_CLOSED;
              nxt.door = 1'b0;
            end
            MODE_UP: begin
              if (cur.sub_step < QUARTERS_TOP) begin
                if (cur.floor_num < TOP_FLOOR) nxt.sub_step = cur.sub_step + 1'b1;
                else status = ST_LIMIT;
              end else begin
                nxt.sub_step  = '0;
                nxt.floor_num = cur.floor_num + 1'b1;
                if (cur.stop_request) begin
                  nxt.mode         = MODE_IDLE_CLOSED;
                  nxt.direction    = DIR_STAND;
                  nxt.stop_request = 1'b0;
                end
              end
            end
            MODE_DOWN: begin
              if (cur.sub_step == '0) begin
                if (cur.floor_num != '0) begin
                  nxt.sub_step  = QUARTERS_TOP;
                  nxt.floor_num = cur.floor_num - 1'b1;
                end else begin
                  status = ST_LIMIT;
                end
              end else begin
                nxt.sub_step = cur.sub_step - 1'b1;
                // Level at the floor once the last quarter is done
                if (cur.sub_step == SUB_W'(1) && cur.stop_request) begin
                  nxt.mode         = MODE_IDLE_CLOSED;
                  nxt.direction    = DIR_STAND;
                  nxt.stop_request = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      EV_ACTION: begin
        if (cur.mode == MODE_HALTED) begin
          status = ST_HALTED;
        end else if (act == ACT_STOP) begin
          nxt.stop_request = 1'b1;
        end else if (act > ACT_CLOSE) begin
          status = ST_MISMATCH;
        end else if (cur.pending_valid) begin
          status = ST_BUSY;
        end else begin
          nxt.pending_valid = 1'b1;
          nxt.pending_code  = act;
        end
      end
      default: begin
        // Lamp on or off
        if ({1'b0, lamp_floor} >= FLOOR_CNT) begin
          status = ST_BAD_FLOOR;
        end else if (ev == EV_LAMP_ON) begin
          nxt.lamps[lamp_floor] = 1'b1;
        end else begin
          nxt.lamps[lamp_floor] = 1'b0;
        end
      end
    endcase
  end

endmodule
